// ===== sv/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg - shared definitions for the binary to decimal ASCII converter
// Widths, character codes, the controller state type and the BCD digit
// correction used by the shift-and-add-3 conversion.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int WORD_W     = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CHAR_W     = 8;
  localparam int BIT_CNT_W  = $clog2(WORD_W);
  localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(WORD_W - 1);
  localparam logic [LEFT_W-1:0]    ALL_DIGITS = LEFT_W'(NUM_DIGITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_DIGIT
  } bda_state_t;

  // A digit of five or more doubles past nine, so it is corrected by three first.
  function automatic logic [DIGIT_W-1:0] dabble_adjust(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
    return r;
  endfunction

endpackage

// ===== sv/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii - 32-bit word to decimal ASCII text
// Bit-serial shift-and-add-3 conversion followed by a character sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_axis_*) carries one word per transaction: tdata is
//   the 32-bit value, tuser selects signed (1) or unsigned (0) reading.
//   The output channel (m_axis_*) returns the decimal text one ASCII
//   character per transaction, most significant digit first, with a leading
//   '-' for negative signed words and tlast on the final character.
//   Operation: after the input transaction the word is shifted into the BCD
//   register one bit per cycle, then leading zero digits are dropped one
//   per cycle (up to nine digits), the skip state then moves on to the sign
//   or first digit, and characters leave one per cycle through the output
//   register while the receiver is ready. A new word is accepted once the
//   last character of the previous one is loaded into the output register.
//   Reset clears the controller and the output valid; no word is pending.
//   When the receiver stalls the output register holds its character and
//   the sequencer waits; no character is lost or repeated.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
  import bda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [WORD_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic              s_axis_tuser,   // [0] func (1 = signed)
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [CHAR_W-1:0] m_axis_tdata,   // [7:0] char_code
  output logic              m_axis_tlast    // last
);

  bda_state_t           state, state_next;
  logic [WORD_W-1:0]    mag_sr, mag_sr_next;
  logic [BCD_W-1:0]     bcd, bcd_next;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;
  logic [LEFT_W-1:0]    left, left_next;
  logic                 neg, neg_next;
  logic                 out_valid, out_valid_next;
  logic [CHAR_W-1:0]    char_code, char_code_next;
  logic                 out_last, out_last_next;
  logic                 slot_free;
  logic                 in_fire;
  logic [DIGIT_W-1:0]   top_digit;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid || m_axis_tready;
  assign top_digit     = bcd[BCD_W-1 -: DIGIT_W];

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = char_code;
  assign m_axis_tlast  = out_last;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i*DIGIT_W +: DIGIT_W] = dabble_adjust(bcd[i*DIGIT_W +: DIGIT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mag_sr    <= mag_sr_next;
    bcd       <= bcd_next;
    bit_cnt   <= bit_cnt_next;
    left      <= left_next;
    neg       <= neg_next;
    char_code <= char_code_next;
    out_last  <= out_last_next;
  end

  always_comb begin
    state_next     = state;
    mag_sr_next    = mag_sr;
    bcd_next       = bcd;
    bit_cnt_next   = bit_cnt;
    left_next      = left;
    neg_next       = neg;
    out_valid_next = out_valid && !m_axis_tready;
    char_code_next = char_code;
    out_last_next  = out_last;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          neg_next     = s_axis_tuser && s_axis_tdata[WORD_W-1];
          // The unsigned negation also covers the most negative word.
          mag_sr_next  = neg_next ? (WORD_W'(0) - s_axis_tdata) : s_axis_tdata;
          bcd_next     = '0;
          bit_cnt_next = '0;
          left_next    = ALL_DIGITS;
          state_next   = S_CONV;
        end
      end
      S_CONV: begin
        bcd_next     = {bcd_adj[BCD_W-2:0], mag_sr[WORD_W-1]};
        mag_sr_next  = {mag_sr[WORD_W-2:0], 1'b0};
        bit_cnt_next = bit_cnt + BIT_CNT_W'(1);
        if (bit_cnt == LAST_BIT) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        // Drop leading zeros, but always keep the units digit.
        if (top_digit == '0 && left != LEFT_W'(1)) begin
          bcd_next  = {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          left_next = left - LEFT_W'(1);
        end else begin
          state_next = neg ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          char_code_next = ASCII_MINUS;
          out_last_next  = 1'b0;
          state_next     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          char_code_next = ASCII_ZERO + CHAR_W'(top_digit);
          out_last_next  = (left == LEFT_W'(1));
          bcd_next       = {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          left_next      = left - LEFT_W'(1);
          if (left == LEFT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_char_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == ASCII_MINUS ||
                   (char_code >= ASCII_ZERO && char_code <= ASCII_NINE)))
    else $error("output character is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_code == ASCII_MINUS) |-> !out_last)
    else $error("minus sign flagged as last character");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_CONV && bit_cnt == '0))
    else $error("accepted word did not start the conversion");

  a_bcd_digit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> (top_digit <= DIGIT_W'(9) && left != '0))
    else $error("emitted digit out of BCD range or no digits left");

  a_sign_only_neg: assert property (@(posedge clk) disable iff (rst)
    (state == S_SIGN) |-> neg)
    else $error("sign state entered for a non-negative word");
`endif

endmodule
